@@ src/joystick_axis_deadzone_mapper_assert.svh @@
// Assertion macros shared by the joystick axis dead-zone mapper RTL.
`ifndef JOYSTICK_AXIS_DEADZONE_MAPPER_ASSERT_SVH
`define JOYSTICK_AXIS_DEADZONE_MAPPER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JADM_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define JADM_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/jadm_pkg.sv @@
// Shared types, codes and defaults of the joystick axis dead-zone mapper.
package jadm_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int ZONE_BITS         = 15;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int DEAD_ZONE_RST     = 5000;
    localparam int MAX_ZONE_RST      = 30000;

    localparam logic [CFG_INDEX_BITS-1:0] REG_DEAD_ZONE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_ZONE  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_THROTTLE  = 2'd2;

    localparam logic [1:0] THR_NORMAL = 2'b00;
    localparam logic [1:0] THR_POS    = 2'b01;
    localparam logic [1:0] THR_NEG    = 2'b11;

    localparam logic [1:0] TR_NONE    = 2'd0;
    localparam logic [1:0] TR_ACTIVE  = 2'd1;
    localparam logic [1:0] TR_RELEASE = 2'd2;

    localparam logic [1:0] BTN_NONE = 2'd0;
    localparam logic [1:0] BTN_NEG  = 2'd1;
    localparam logic [1:0] BTN_POS  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FOLD,
        ST_MAG,
        ST_EVAL,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

@@ src/joystick_axis_deadzone_mapper.sv @@
// Top level of the joystick axis dead-zone mapper: fold, zone tracking, button events, distance.
//
// Each accepted sample yields exactly one result beat. A sample passes through capture,
// throttle folding, magnitude and evaluation, then the serial divider at one fraction bit
// per cycle, then the output load. Samples below the dead zone or at or beyond the max zone,
// and every sample while the max zone does not exceed the dead zone, skip the divider. One
// sample is in flight at a time; the next one is taken as soon as the current one has moved
// to the output register, even while that result still waits for i_out_ready. Configuration
// writes are taken outside reset and must only be issued while no sample is in flight.
module joystick_axis_deadzone_mapper
    import jadm_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_raw_value,
    input  logic                      i_ignore_sets,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_moved_value,
    output logic signed [SAMPLE_BITS-1:0] o_throttled_value,
    output logic [1:0]                o_transition,
    output logic [1:0]                o_button_target,
    output logic                      o_button_pressed,
    output logic                      o_button_ignore_sets,
    output logic [FRACTION_BITS:0]    o_distance,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [ZONE_BITS-1:0]      i_cfg_data
);

`include "joystick_axis_deadzone_mapper_assert.svh"

    localparam int WIDE     = ((SAMPLE_BITS > ZONE_BITS) ? SAMPLE_BITS : ZONE_BITS) + 1;
    localparam int ZONE_CAP = (SAMPLE_BITS - 1 < ZONE_BITS) ?
                              (1 << (SAMPLE_BITS - 1)) - 1 : (1 << ZONE_BITS) - 1;
    localparam int MAX_RST  = (MAX_ZONE_RST > ZONE_CAP) ? ZONE_CAP : MAX_ZONE_RST;
    localparam logic [ZONE_BITS-1:0] ZONE_CAP_V = ZONE_CAP[ZONE_BITS-1:0];
    localparam logic [ZONE_BITS-1:0] MAX_RST_V  = MAX_RST[ZONE_BITS-1:0];
    localparam logic [ZONE_BITS-1:0] DEAD_RST_V = DEAD_ZONE_RST[ZONE_BITS-1:0];
    localparam logic [SAMPLE_BITS:0] AXIS_MAX_W = {2'b00, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS:0] AXIS_MIN_W = {2'b11, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [FRACTION_BITS:0] FULL_SCALE = {1'b1, {FRACTION_BITS{1'b0}}};

    t_state r_state;
    t_state n_state;

    logic [ZONE_BITS-1:0]   r_dead_zone;
    logic [ZONE_BITS-1:0]   r_max_zone;
    logic [1:0]             r_throttle;
    logic                   r_active;
    logic [1:0]             r_held;
    logic                   n_active;
    logic [1:0]             n_held;

    logic [SAMPLE_BITS-1:0] r_raw;
    logic                   r_ign;
    logic [SAMPLE_BITS-1:0] r_thr;
    logic [WIDE-1:0]        r_mag;
    logic                   r_neg;
    logic [ZONE_BITS-1:0]   r_den;
    logic                   r_span_ok;
    logic [1:0]             r_trans;
    logic [1:0]             r_target;
    logic                   r_pressed;
    logic                   r_fwd;
    logic [FRACTION_BITS:0] r_dist;
    logic [1:0]             n_trans;
    logic [1:0]             n_target;
    logic                   n_pressed;
    logic                   n_fwd;

    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_o_moved;
    logic [SAMPLE_BITS-1:0] r_o_thr;
    logic [1:0]             r_o_trans;
    logic [1:0]             r_o_target;
    logic                   r_o_pressed;
    logic                   r_o_fwd;
    logic [FRACTION_BITS:0] r_o_dist;

    logic                   w_in_ready;
    logic                   w_div_start;
    logic                   w_load_out;
    logic                   w_accept;
    logic                   w_div_done;
    logic [FRACTION_BITS-1:0] w_quot;

    logic [SAMPLE_BITS:0]   w_ext;
    logic [SAMPLE_BITS:0]   w_off;
    logic [SAMPLE_BITS:0]   w_sum;
    logic [SAMPLE_BITS:0]   w_sum_r;
    logic [SAMPLE_BITS-1:0] w_fold;
    logic [WIDE-1:0]        w_thr_w;
    logic [WIDE-1:0]        w_mag;
    logic [WIDE-1:0]        w_dead_w;
    logic [WIDE-1:0]        w_excess;
    logic                   w_outside;
    logic                   w_below;
    logic                   w_big;
    logic                   w_need_div;
    logic                   w_event;

    assign w_accept    = i_in_valid && w_in_ready;
    assign o_cfg_ready = i_rst_n;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= DEAD_RST_V;
            r_max_zone  <= MAX_RST_V;
            r_throttle  <= THR_NORMAL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DEAD_ZONE: r_dead_zone <= i_cfg_data;
                REG_MAX_ZONE:  r_max_zone  <= (i_cfg_data > ZONE_CAP_V) ? ZONE_CAP_V : i_cfg_data;
                REG_THROTTLE: begin
                    if (i_cfg_data[1:0] == THR_NORMAL || i_cfg_data[1:0] == THR_POS ||
                        i_cfg_data[1:0] == THR_NEG) begin
                        r_throttle <= i_cfg_data[1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // Throttle fold, halving with truncation toward zero
    assign w_ext   = {r_raw[SAMPLE_BITS-1], r_raw};
    assign w_off   = (r_throttle == THR_NEG) ? AXIS_MIN_W : AXIS_MAX_W;
    assign w_sum   = w_ext + w_off;
    assign w_sum_r = w_sum + {{SAMPLE_BITS{1'b0}}, w_sum[SAMPLE_BITS]};
    assign w_fold  = (r_throttle == THR_NORMAL) ? r_raw : w_sum_r[SAMPLE_BITS:1];

    // Magnitude
    assign w_thr_w = {{(WIDE-SAMPLE_BITS){r_thr[SAMPLE_BITS-1]}}, r_thr};
    assign w_mag   = r_thr[SAMPLE_BITS-1] ? (~w_thr_w + 1'b1) : w_thr_w;

    // Zone compare and divider operands
    assign w_dead_w   = {{(WIDE-ZONE_BITS){1'b0}}, r_dead_zone};
    assign w_outside  = r_mag > w_dead_w;
    assign w_below    = r_mag < w_dead_w;
    assign w_excess   = r_mag - w_dead_w;
    assign w_big      = w_excess >= {{(WIDE-ZONE_BITS){1'b0}}, r_den};
    assign w_need_div = !w_below && r_span_ok && !w_big;

    // Activation, release and button events
    always_comb begin
        n_active  = r_active;
        n_held    = r_held;
        n_trans   = TR_NONE;
        n_target  = BTN_NONE;
        n_pressed = 1'b0;
        n_fwd     = 1'b0;
        w_event   = r_active;
        if (w_outside && !r_active) begin
            n_active = 1'b1;
            n_trans  = TR_ACTIVE;
            w_event  = 1'b1;
        end else if (!w_outside && r_active) begin
            n_active = 1'b0;
            n_trans  = TR_RELEASE;
        end
        if (w_event) begin
            if (w_outside && !r_neg) begin
                n_target = BTN_POS;
                n_held   = BTN_POS;
            end else if (w_outside) begin
                n_target = BTN_NEG;
                n_held   = BTN_NEG;
            end else if (r_held != BTN_NONE) begin
                n_target = r_held;
                n_held   = BTN_NONE;
            end
            if (n_target != BTN_NONE) begin
                n_pressed = n_active;
                n_fwd     = r_ign;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_FOLD;
            ST_FOLD: n_state = ST_MAG;
            ST_MAG:  n_state = ST_EVAL;
            ST_EVAL: n_state = w_need_div ? ST_DIV : ST_DONE;
            ST_DIV:  if (w_div_done) n_state = ST_DONE;
            ST_DONE: if (w_load_out) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            ST_IDLE: w_in_ready  = i_rst_n;
            ST_EVAL: w_div_start = w_need_div;
            ST_DONE: w_load_out  = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= 1'b0;
            r_held      <= BTN_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EVAL) begin
                r_active <= n_active;
                r_held   <= n_held;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_raw <= i_raw_value;
            r_ign <= i_ignore_sets;
        end
        if (r_state == ST_FOLD) begin
            r_thr <= w_fold;
        end
        if (r_state == ST_MAG) begin
            r_mag     <= w_mag;
            r_neg     <= r_thr[SAMPLE_BITS-1];
            r_den     <= r_max_zone - r_dead_zone;
            r_span_ok <= r_max_zone > r_dead_zone;
        end
        if (r_state == ST_EVAL) begin
            r_trans   <= n_trans;
            r_target  <= n_target;
            r_pressed <= n_pressed;
            r_fwd     <= n_fwd;
            r_dist    <= w_below ? '0 : FULL_SCALE;
        end
        if (r_state == ST_DIV && w_div_done) begin
            r_dist <= {1'b0, w_quot};
        end
        if (w_load_out) begin
            r_o_moved   <= r_raw;
            r_o_thr     <= r_thr;
            r_o_trans   <= r_trans;
            r_o_target  <= r_target;
            r_o_pressed <= r_pressed;
            r_o_fwd     <= r_fwd;
            r_o_dist    <= r_dist;
        end
    end

    jadm_div #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_excess[ZONE_BITS-1:0]),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_in_ready           = w_in_ready;
    assign o_out_valid          = r_out_valid;
    assign o_moved_value        = r_o_moved;
    assign o_throttled_value    = r_o_thr;
    assign o_transition         = r_o_trans;
    assign o_button_target      = r_o_target;
    assign o_button_pressed     = r_o_pressed;
    assign o_button_ignore_sets = r_o_fwd;
    assign o_distance           = r_o_dist;

    `JADM_ASSERT_IMP(a_held_tracks_active, 1'b1, r_active == (r_held != BTN_NONE),
        "held button disagrees with axis activity")
    `JADM_ASSERT_IMP(a_div_done_in_div, w_div_done, r_state == ST_DIV,
        "divider finished outside the divide state")
    `JADM_ASSERT_NXT(a_load_sets_valid, w_load_out, r_out_valid,
        "output beat lost after load")
    `JADM_ASSERT_IMP(a_dist_in_range, r_out_valid, r_o_dist <= FULL_SCALE,
        "distance beyond full scale")
    `JADM_ASSERT_IMP(a_press_needs_target, r_out_valid && r_o_target == BTN_NONE,
        !r_o_pressed && !r_o_fwd, "button fields set without a target")

endmodule

@@ src/jadm_div.sv @@
// Bit-serial restoring divider producing the fraction bits of the distance.
module jadm_div
    import jadm_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [ZONE_BITS-1:0]     i_num,
    input  logic [ZONE_BITS-1:0]     i_den,
    output logic                     o_done,
    output logic [FRACTION_BITS-1:0] o_quot
);

    localparam int CNT_BITS = $clog2(FRACTION_BITS + 1);

    logic [ZONE_BITS-1:0]     r_rem;
    logic [ZONE_BITS-1:0]     n_rem;
    logic [FRACTION_BITS-1:0] r_quot;
    logic [CNT_BITS-1:0]      r_cnt;
    logic                     r_busy;
    logic                     r_done;
    logic [ZONE_BITS:0]       w_two;
    logic [ZONE_BITS+1:0]     w_diff;
    logic                     w_fit;

    assign w_two  = {r_rem, 1'b0};
    assign w_diff = {1'b0, w_two} - {2'b00, i_den};
    assign w_fit  = !w_diff[ZONE_BITS+1];
    assign n_rem  = w_fit ? w_diff[ZONE_BITS-1:0] : w_two[ZONE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(FRACTION_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[FRACTION_BITS-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
